// ===== src/mtt_pkg.sv =====
// Shared types and constants for the markup tag tokenizer.
// Holds the byte classes, parser modes, token kinds and the queue item struct.
// No dependencies.
package mtt_pkg;

    // Character constants used by the classifier.
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;

    // Number of dashes that must precede '>' to close a comment.
    localparam logic [1:0] DASH_CLOSE = 2'd2;
    localparam logic [1:0] DASH_SAT   = 2'd3;

    // Byte classes produced by the front end.
    typedef enum logic [3:0] {
        CL_LT,
        CL_GT,
        CL_SLASH,
        CL_BANG,
        CL_QUOTE,
        CL_EQ,
        CL_DASH,
        CL_NL,
        CL_SPACE,
        CL_LETTER,
        CL_OTHER,
        CL_END
    } class_t;

    // Parser modes of the back end.
    typedef enum logic [3:0] {
        M_TEXT,
        M_MARKUP,
        M_NAME,
        M_WHITE,
        M_EMPTY,
        M_KEY,
        M_EQ,
        M_VAL,
        M_CLOSE,
        M_COMMENT,
        M_HALT
    } mode_t;

    // Token kinds as reported on the result channel.
    typedef enum logic [4:0] {
        T_TEXT      = 5'd0,
        T_MARK      = 5'd1,
        T_NAME      = 5'd2,
        T_KEY       = 5'd3,
        T_EQ        = 5'd4,
        T_OQ        = 5'd5,
        T_VAL       = 5'd6,
        T_CQ        = 5'd7,
        T_SPACE     = 5'd8,
        T_SLASH     = 5'd9,
        T_OPEN_END  = 5'd10,
        T_EMPTY_END = 5'd11,
        T_CNAME     = 5'd12,
        T_CLOSE_END = 5'd13,
        T_CSTART    = 5'd14,
        T_CBYTE     = 5'd15,
        T_CEND      = 5'd16,
        T_ERR       = 5'd17,
        T_END_OK    = 5'd18,
        T_END_INC   = 5'd19,
        T_HALT      = 5'd20
    } kind_t;

    // One classified item as it travels from front to back.
    typedef struct packed {
        class_t     cls;
        logic [7:0] data;
    } item_t;

endpackage

// ===== src/mtt_classify.sv =====
// Front end of the markup tag tokenizer: sorts each input byte into a class.
// Depends on mtt_pkg.
module mtt_classify
    import mtt_pkg::*;
(
    input  logic [7:0] data_byte,
    input  logic       is_end,
    output item_t      item
);

    // Map the byte onto the classes that the parser distinguishes.
    always_comb
    begin
        item.data = is_end ? 8'h00 : data_byte;
        if (is_end)
        begin
            item.cls = CL_END;
        end
        else if (data_byte == CH_LT)
        begin
            item.cls = CL_LT;
        end
        else if (data_byte == CH_GT)
        begin
            item.cls = CL_GT;
        end
        else if (data_byte == CH_SLASH)
        begin
            item.cls = CL_SLASH;
        end
        else if (data_byte == CH_BANG)
        begin
            item.cls = CL_BANG;
        end
        else if (data_byte == CH_QUOTE)
        begin
            item.cls = CL_QUOTE;
        end
        else if (data_byte == CH_EQ)
        begin
            item.cls = CL_EQ;
        end
        else if (data_byte == CH_DASH)
        begin
            item.cls = CL_DASH;
        end
        else if (data_byte == CH_NL)
        begin
            item.cls = CL_NL;
        end
        else if (data_byte == CH_SP || data_byte == CH_TAB)
        begin
            item.cls = CL_SPACE;
        end
        else if ((data_byte >= 8'h41 && data_byte <= 8'h5A) ||
                 (data_byte >= 8'h61 && data_byte <= 8'h7A))
        begin
            item.cls = CL_LETTER;
        end
        else
        begin
            item.cls = CL_OTHER;
        end
    end

endmodule

// ===== src/mtt_queue.sv =====
// Two-entry queue that decouples the classifier from the parser.
// Depends on mtt_pkg.
module mtt_queue
    import mtt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head_item,
    output logic  not_empty,
    output logic  not_full
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign not_empty = (count_reg != 2'd0);
    assign not_full  = (count_reg != 2'd2);
    assign head_item = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/mtt_engine.sv =====
// Back end of the markup tag tokenizer: parser state machine, depth, line and
// column counters, and the registered result. Depends on mtt_pkg.
module mtt_engine
    import mtt_pkg::*;
#(
    parameter int MAX_DEPTH = 255,
    parameter int POS_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  logic        item_valid,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_kind,
    output logic [7:0]  token_byte,
    output logic [7:0]  nest_depth,
    output logic [15:0] line_number,
    output logic [15:0] column_number
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    mode_t                mode_reg;
    mode_t                mode_next;
    logic [1:0]           dash_reg;
    logic [1:0]           dash_next;
    logic [DW-1:0]        depth_reg;
    logic [DW-1:0]        depth_next;
    logic [POS_BITS-1:0]  line_reg;
    logic [POS_BITS-1:0]  line_next;
    logic [POS_BITS-1:0]  col_reg;
    logic [POS_BITS-1:0]  col_next;
    kind_t                kind_reg;
    kind_t                kind_next;
    logic [7:0]           byte_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                 is_letter;
    logic                 is_space;
    logic                 depth_room;
    logic                 depth_nonzero;
    logic [DW+7:0]        depth_wide;
    logic [POS_BITS+15:0] line_wide;
    logic [POS_BITS+15:0] col_wide;

    assign is_letter     = (item.cls == CL_LETTER);
    assign is_space      = (item.cls == CL_SPACE) || (item.cls == CL_NL);
    assign depth_room    = (depth_reg < DEPTH_MAX);
    assign depth_nonzero = (depth_reg != '0);

    // Take the head item whenever the result register is free or draining.
    assign pop = item_valid && (!out_valid_reg || out_ready);

    // Next parser mode.
    always_comb
    begin
        mode_next = M_HALT;
        if (item.cls == CL_END)
        begin
            mode_next = mode_reg;
        end
        else
        begin
            case (mode_reg)
                M_TEXT:
                begin
                    mode_next = (item.cls == CL_LT) ? M_MARKUP : M_TEXT;
                end
                M_MARKUP:
                begin
                    if (is_letter)
                        mode_next = M_NAME;
                    else if (item.cls == CL_SLASH)
                        mode_next = M_CLOSE;
                    else if (item.cls == CL_BANG)
                        mode_next = M_COMMENT;
                end
                M_NAME, M_WHITE:
                begin
                    if (is_letter)
                        mode_next = (mode_reg == M_NAME) ? M_NAME : M_KEY;
                    else if (item.cls == CL_GT && depth_room)
                        mode_next = M_TEXT;
                    else if (item.cls == CL_SLASH)
                        mode_next = M_EMPTY;
                    else if (is_space)
                        mode_next = M_WHITE;
                end
                M_EMPTY:
                begin
                    if (item.cls == CL_GT)
                        mode_next = M_TEXT;
                end
                M_KEY:
                begin
                    if (is_letter)
                        mode_next = M_KEY;
                    else if (item.cls == CL_EQ)
                        mode_next = M_EQ;
                end
                M_EQ:
                begin
                    if (item.cls == CL_QUOTE)
                        mode_next = M_VAL;
                end
                M_VAL:
                begin
                    mode_next = (item.cls == CL_QUOTE) ? M_WHITE : M_VAL;
                end
                M_CLOSE:
                begin
                    if (is_letter)
                        mode_next = M_CLOSE;
                    else if (item.cls == CL_GT && depth_nonzero)
                        mode_next = M_TEXT;
                end
                M_COMMENT:
                begin
                    if (item.cls == CL_GT && dash_reg == DASH_CLOSE)
                        mode_next = M_TEXT;
                    else
                        mode_next = M_COMMENT;
                end
                default:
                begin
                    mode_next = M_HALT;
                end
            endcase
        end
    end

    // Token kind for the current item.
    always_comb
    begin
        kind_next = T_ERR;
        if (mode_reg == M_HALT)
        begin
            kind_next = T_HALT;
        end
        else if (item.cls == CL_END)
        begin
            kind_next = (mode_reg == M_TEXT) ? T_END_OK : T_END_INC;
        end
        else if (mode_next == M_HALT)
        begin
            kind_next = T_ERR;
        end
        else
        begin
            case (mode_reg)
                M_TEXT:
                    kind_next = (item.cls == CL_LT) ? T_MARK : T_TEXT;
                M_MARKUP:
                begin
                    if (is_letter)
                        kind_next = T_NAME;
                    else if (item.cls == CL_SLASH)
                        kind_next = T_SLASH;
                    else
                        kind_next = T_CSTART;
                end
                M_NAME, M_WHITE:
                begin
                    if (is_letter)
                        kind_next = (mode_reg == M_NAME) ? T_NAME : T_KEY;
                    else if (item.cls == CL_GT)
                        kind_next = T_OPEN_END;
                    else if (item.cls == CL_SLASH)
                        kind_next = T_SLASH;
                    else
                        kind_next = T_SPACE;
                end
                M_EMPTY:
                    kind_next = T_EMPTY_END;
                M_KEY:
                    kind_next = is_letter ? T_KEY : T_EQ;
                M_EQ:
                    kind_next = T_OQ;
                M_VAL:
                    kind_next = (item.cls == CL_QUOTE) ? T_CQ : T_VAL;
                M_CLOSE:
                    kind_next = is_letter ? T_CNAME : T_CLOSE_END;
                M_COMMENT:
                    kind_next = (mode_next == M_TEXT) ? T_CEND : T_CBYTE;
                default:
                    kind_next = T_ERR;
            endcase
        end
    end

    // Dash run, nesting depth and position counters.
    always_comb
    begin
        dash_next  = dash_reg;
        depth_next = depth_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        if (mode_reg != M_HALT && item.cls != CL_END)
        begin
            if (col_reg != '1)
            begin
                col_next = col_reg + 1'b1;
            end
            if (mode_reg == M_TEXT && item.cls == CL_NL)
            begin
                col_next = '0;
                if (line_reg != '1)
                begin
                    line_next = line_reg + 1'b1;
                end
            end
            if (mode_reg == M_MARKUP && item.cls == CL_BANG)
            begin
                dash_next = 2'd0;
            end
            if (mode_reg == M_COMMENT)
            begin
                if (item.cls == CL_DASH)
                begin
                    if (dash_reg != DASH_SAT)
                    begin
                        dash_next = dash_reg + 2'd1;
                    end
                end
                else
                begin
                    dash_next = 2'd0;
                end
            end
            if ((mode_reg == M_NAME || mode_reg == M_WHITE) &&
                item.cls == CL_GT && depth_room)
            begin
                depth_next = depth_reg + 1'b1;
            end
            if (mode_reg == M_CLOSE && item.cls == CL_GT && depth_nonzero)
            begin
                depth_next = depth_reg - 1'b1;
            end
        end
    end

    // Result register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_TEXT;
            dash_reg      <= 2'd0;
            depth_reg     <= '0;
            line_reg      <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                mode_reg  <= mode_next;
                dash_reg  <= dash_next;
                depth_reg <= depth_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
            end
        end
    end

    // Token payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= kind_next;
            byte_reg <= item.data;
        end
    end

    // The state registers change only with a new result, so they are the
    // depth and position of the result on display.
    assign depth_wide    = {8'b0, depth_reg};
    assign line_wide     = {16'b0, line_reg};
    assign col_wide      = {16'b0, col_reg};
    assign out_valid     = out_valid_reg;
    assign token_kind    = kind_reg;
    assign token_byte    = byte_reg;
    assign nest_depth    = depth_wide[7:0];
    assign line_number   = line_wide[15:0];
    assign column_number = col_wide[15:0];

endmodule

// ===== src/markup_tag_tokenizer.sv =====
// Top level of the markup tag tokenizer.
// Depends on mtt_pkg, mtt_classify, mtt_queue and mtt_engine.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one source byte per
//   transaction in data_byte, or an end marker when is_end is high.
//   Output channel (out_valid/out_ready) returns exactly one token per
//   input transaction: token_kind, token_byte, and the nesting depth,
//   line and column after that byte.
//   An accepted byte is written into the queue, and its token is loaded
//   into the output register when the parser takes it from the queue
//   head. Throughput is one byte per cycle while out_ready stays high.
//   A two-entry queue sits between the classifier and the parser, and the
//   token is held in an output register; when the receiver stalls the
//   queue fills and in_ready drops once both entries are taken.
//   Reset returns the parser to text mode with depth, line and column at
//   zero and empties the queue; a byte that is illegal in its context
//   gives an error token and every later transaction reports halted until
//   the next reset.
module markup_tag_tokenizer
    import mtt_pkg::*;
#(
    parameter int MAX_DEPTH = 255,
    parameter int POS_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_kind,
    output logic [7:0]  token_byte,
    output logic [7:0]  nest_depth,
    output logic [15:0] line_number,
    output logic [15:0] column_number
);

    item_t class_item;
    item_t head_item;
    logic  queue_not_empty;
    logic  queue_not_full;
    logic  queue_pop;

    assign in_ready = queue_not_full;

    // Front end: classify the incoming byte.
    mtt_classify u_classify
    (
        .data_byte (data_byte),
        .is_end    (is_end),
        .item      (class_item)
    );

    // Decoupling queue between classifier and parser.
    mtt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && queue_not_full),
        .push_item (class_item),
        .pop       (queue_pop),
        .head_item (head_item),
        .not_empty (queue_not_empty),
        .not_full  (queue_not_full)
    );

    // Back end: parser state machine and result register.
    mtt_engine #(
        .MAX_DEPTH (MAX_DEPTH),
        .POS_BITS  (POS_BITS)
    ) u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (head_item),
        .item_valid    (queue_not_empty),
        .pop           (queue_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .token_kind    (token_kind),
        .token_byte    (token_byte),
        .nest_depth    (nest_depth),
        .line_number   (line_number),
        .column_number (column_number)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for markup_tag_tokenizer: random and directed byte streams,
// with a built-in token predictor checked against every result transaction.
// Depends on mtt_pkg and the markup_tag_tokenizer RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtt_pkg::*;

    localparam int          MAX_NEST     = 255;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam int          ITEMS_TOTAL  = 1250;
    localparam int          TAIL_ITEMS   = 24;
    localparam int          HOLD_AT      = 150;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          QUIET_FROM   = 600;
    localparam int          QUIET_TO     = 900;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          MAX_PRINTS   = 40;

    // One source transaction: a byte or an end marker.
    typedef struct {
        logic [7:0] data;
        logic       fin;
    } src_item_t;

    // One expected token with the position state after it.
    typedef struct {
        kind_t       kind;
        logic [7:0]  tbyte;
        logic [7:0]  depth;
        logic [15:0] line;
        logic [15:0] col;
    } token_t;

    // The way the stream is broken at its end; the block halts after it.
    typedef enum {
        FIN_BAD_BYTE,
        FIN_CLOSE_AT_ZERO,
        FIN_OVERFLOW
    } finale_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        is_end    = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  token_kind;
    logic [7:0]  token_byte;
    logic [7:0]  nest_depth;
    logic [15:0] line_number;
    logic [15:0] column_number;

    src_item_t source_bytes[$];
    token_t    expected_tokens[$];

    int in_issued   = 0;
    int in_accepts  = 0;
    int out_count   = 0;
    int mismatches  = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    bit noisy       = 1'b0;
    int gen_depth   = 0;

    // Predictor state, mirroring the parser after reset.
    mode_t       tok_mode   = M_TEXT;
    logic [1:0]  tok_dashes = 2'd0;
    logic [7:0]  tok_depth  = 8'd0;
    logic [15:0] tok_line   = 16'd0;
    logic [15:0] tok_col    = 16'd0;

    markup_tag_tokenizer #(
        .MAX_DEPTH (MAX_NEST),
        .POS_BITS  (16)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .is_end        (is_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .token_kind    (token_kind),
        .token_byte    (token_byte),
        .nest_depth    (nest_depth),
        .line_number   (line_number),
        .column_number (column_number)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // Classifies one source transaction and advances the predicted parser state.
    function automatic token_t tokenize(input logic [7:0] c, input logic fin);
        token_t t;
        mode_t  nxt;
        kind_t  kind;
        kind = T_ERR;
        t.tbyte = c;
        if (tok_mode == M_HALT)
        begin
            kind = T_HALT;
            if (fin)
                t.tbyte = 8'h00;
        end
        else if (fin)
        begin
            kind = (tok_mode == M_TEXT) ? T_END_OK : T_END_INC;
            t.tbyte = 8'h00;
        end
        else
        begin
            nxt = M_HALT;
            if (tok_col != POS_MAX)
                tok_col++;
            case (tok_mode)
                M_TEXT:
                begin
                    if (c == CH_LT)
                    begin
                        kind = T_MARK;
                        nxt = M_MARKUP;
                    end
                    else
                    begin
                        kind = T_TEXT;
                        nxt = M_TEXT;
                        // Only newlines in text move the line counter.
                        if (c == CH_NL)
                        begin
                            if (tok_line != POS_MAX)
                                tok_line++;
                            tok_col = 16'd0;
                        end
                    end
                end
                M_MARKUP:
                begin
                    if (is_alpha(c))
                    begin
                        kind = T_NAME;
                        nxt = M_NAME;
                    end
                    else if (c == CH_SLASH)
                    begin
                        kind = T_SLASH;
                        nxt = M_CLOSE;
                    end
                    else if (c == CH_BANG)
                    begin
                        kind = T_CSTART;
                        nxt = M_COMMENT;
                        tok_dashes = 2'd0;
                    end
                end
                M_NAME, M_WHITE:
                begin
                    if (is_alpha(c))
                    begin
                        kind = (tok_mode == M_NAME) ? T_NAME : T_KEY;
                        nxt = (tok_mode == M_NAME) ? M_NAME : M_KEY;
                    end
                    else if (c == CH_GT)
                    begin
                        // An open tag past the depth limit is an error.
                        if (tok_depth < MAX_NEST)
                        begin
                            tok_depth++;
                            kind = T_OPEN_END;
                            nxt = M_TEXT;
                        end
                    end
                    else if (c == CH_SLASH)
                    begin
                        kind = T_SLASH;
                        nxt = M_EMPTY;
                    end
                    else if (c == CH_SP || c == CH_TAB || c == CH_NL)
                    begin
                        kind = T_SPACE;
                        nxt = M_WHITE;
                    end
                end
                M_EMPTY:
                begin
                    if (c == CH_GT)
                    begin
                        kind = T_EMPTY_END;
                        nxt = M_TEXT;
                    end
                end
                M_KEY:
                begin
                    if (is_alpha(c))
                    begin
                        kind = T_KEY;
                        nxt = M_KEY;
                    end
                    else if (c == CH_EQ)
                    begin
                        kind = T_EQ;
                        nxt = M_EQ;
                    end
                end
                M_EQ:
                begin
                    if (c == CH_QUOTE)
                    begin
                        kind = T_OQ;
                        nxt = M_VAL;
                    end
                end
                M_VAL:
                begin
                    kind = (c == CH_QUOTE) ? T_CQ : T_VAL;
                    nxt = (c == CH_QUOTE) ? M_WHITE : M_VAL;
                end
                M_CLOSE:
                begin
                    if (is_alpha(c))
                    begin
                        kind = T_CNAME;
                        nxt = M_CLOSE;
                    end
                    else if (c == CH_GT && tok_depth != 8'd0)
                    begin
                        tok_depth--;
                        kind = T_CLOSE_END;
                        nxt = M_TEXT;
                    end
                end
                M_COMMENT:
                begin
                    // The dash run saturates, so only exactly two dashes close.
                    kind = T_CBYTE;
                    nxt = M_COMMENT;
                    if (c == CH_DASH)
                    begin
                        if (tok_dashes != DASH_SAT)
                            tok_dashes++;
                    end
                    else if (tok_dashes == DASH_CLOSE && c == CH_GT)
                    begin
                        kind = T_CEND;
                        nxt = M_TEXT;
                        tok_dashes = 2'd0;
                    end
                    else
                        tok_dashes = 2'd0;
                end
                default:
                begin
                end
            endcase
            if (nxt == M_HALT)
                kind = T_ERR;
            tok_mode = nxt;
        end
        t.kind = kind;
        t.depth = tok_depth;
        t.line = tok_line;
        t.col = tok_col;
        return t;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at token %0d: %s", out_count, msg);
        mismatches++;
    endtask

    function automatic bit take_break();
        if (in_accepts >= QUIET_FROM && in_accepts < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < 22;
    endfunction

    // Stream building helpers; the generator tracks depth to stay well-formed.
    function automatic logic [7:0] any_but(input logic [7:0] avoid);
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (c == avoid)
            c = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic void put_end();
        src_item_t it;
        it.data = 8'($urandom_range(255));
        it.fin = 1'b1;
        source_bytes = {source_bytes, it};
    endfunction

    function automatic void put_byte(input logic [7:0] c);
        src_item_t it;
        if (noisy && $urandom_range(99) < 3)
            put_end();
        it.data = c;
        it.fin = 1'b0;
        source_bytes = {source_bytes, it};
    endfunction

    function automatic void put_string(input string s);
        for (int k = 0; k < s.len(); k++)
            put_byte(s[k]);
    endfunction

    function automatic void put_letters(input int lo, input int hi);
        logic [7:0] c;
        repeat ($urandom_range(hi, lo))
        begin
            c = 8'($urandom_range(25));
            put_byte(($urandom_range(1) == 0) ? ("A" + c) : ("a" + c));
        end
    endfunction

    function automatic void put_blank();
        case ($urandom_range(2))
            0: put_byte(CH_SP);
            1: put_byte(CH_TAB);
            default: put_byte(CH_NL);
        endcase
    endfunction

    function automatic void put_text_run();
        repeat ($urandom_range(6, 1))
        begin
            if ($urandom_range(99) < 15)
                put_byte(CH_NL);
            else
                put_byte(any_but(CH_LT));
        end
    endfunction

    function automatic void put_open_tag(input int empty_pct);
        int n_attr;
        put_byte(CH_LT);
        put_letters(1, 5);
        n_attr = $urandom_range(2);
        for (int k = 0; k < n_attr; k++)
        begin
            if (k == 0 || $urandom_range(1) == 0)
                put_blank();
            put_letters(1, 4);
            put_byte(CH_EQ);
            put_byte(CH_QUOTE);
            repeat ($urandom_range(4))
                put_byte(any_but(CH_QUOTE));
            put_byte(CH_QUOTE);
        end
        if ($urandom_range(2) == 0)
            put_blank();
        if (gen_depth >= MAX_NEST || $urandom_range(99) < empty_pct)
        begin
            put_byte(CH_SLASH);
            put_byte(CH_GT);
        end
        else
        begin
            put_byte(CH_GT);
            gen_depth++;
        end
    endfunction

    function automatic void put_close_tag();
        put_byte(CH_LT);
        put_byte(CH_SLASH);
        put_letters(0, 5);
        put_byte(CH_GT);
        gen_depth--;
    endfunction

    function automatic void put_comment();
        int         d;
        int         r;
        logic [7:0] c;
        d = 0;
        put_byte(CH_LT);
        put_byte(CH_BANG);
        // Body rich in dashes and '>', never closing early.
        repeat ($urandom_range(8))
        begin
            r = $urandom_range(9);
            c = (r < 4) ? CH_DASH : (r < 6) ? CH_GT : 8'($urandom_range(255));
            if (c == CH_DASH)
            begin
                if (d < 3)
                    d++;
            end
            else
            begin
                if (c == CH_GT && d == 2)
                    c = "x";
                d = 0;
            end
            put_byte(c);
        end
        if (d != 0)
            put_byte("x");
        put_string("-->");
    endfunction

    // Upper bound on the bytes that the chosen ending still needs.
    function automatic int finale_cost(input finale_t f);
        case (f)
            FIN_BAD_BYTE:      return 5;
            FIN_CLOSE_AT_ZERO: return 8 * gen_depth + 3;
            default:           return 3 * (MAX_NEST - gen_depth) + 3;
        endcase
    endfunction

    // Stimulus: directed opening, random well-formed stream sized to the item
    // budget, one terminal error and a halted tail. Then wait for all tokens.
    initial
    begin
        int         r;
        finale_t    finale;
        logic [7:0] c;

        finale = finale_t'($urandom_range(2));

        put_end();
        put_byte(8'h00);
        put_string("<A k=\"");
        put_byte(8'hFF);
        put_string("\"/>");
        put_string("<q>");
        put_end();
        put_string("</>");
        put_string("<!");
        put_end();
        put_string("--->-->");

        noisy = 1'b1;
        while (source_bytes.size() + finale_cost(finale) + TAIL_ITEMS < ITEMS_TOTAL)
        begin
            r = $urandom_range(99);
            if (r < 25)
                put_text_run();
            else if (r < 55)
                put_open_tag(30);
            else if (r < 80)
            begin
                if (gen_depth > 0)
                    put_close_tag();
                else
                    put_text_run();
            end
            else if (r < 92)
                put_comment();
            else
                put_end();
        end
        noisy = 1'b0;

        case (finale)
            FIN_BAD_BYTE:
            begin
                if ($urandom_range(1) == 0)
                begin
                    put_byte(CH_LT);
                    c = 8'($urandom_range(255));
                    while (is_alpha(c) || c == CH_SLASH || c == CH_BANG)
                        c = 8'($urandom_range(255));
                end
                else
                begin
                    put_string("<a k");
                    c = 8'($urandom_range(255));
                    while (is_alpha(c) || c == CH_EQ)
                        c = 8'($urandom_range(255));
                end
                put_byte(c);
            end
            FIN_CLOSE_AT_ZERO:
            begin
                while (gen_depth > 0)
                    put_close_tag();
                put_string("</>");
            end
            default:
            begin
                // Short tags fill the nesting up to its limit, then one more.
                while (gen_depth < MAX_NEST)
                begin
                    put_string("<a>");
                    gen_depth++;
                end
                put_string("<a>");
            end
        endcase

        repeat (TAIL_ITEMS)
        begin
            if ($urandom_range(3) == 0)
                put_end();
            else
                put_byte(8'($urandom_range(255)));
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (source_bytes.size() != 0 || in_accepts != in_issued ||
               expected_tokens.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Source driver: a new transaction is offered only once the last one was taken.
    always @(negedge clk)
    begin
        src_item_t nxt;
        if (rst_n && in_accepts == in_issued)
        begin
            if (source_bytes.size() != 0 && !take_break())
            begin
                nxt = source_bytes.pop_front();
                data_byte <= nxt.data;
                is_end <= nxt.fin;
                in_valid <= 1'b1;
                in_issued++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Token receiver: random stalls plus one long hold-off to back up the queue.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && in_accepts >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !take_break();
    end

    // Monitor: check each token transaction, then predict from each byte transaction.
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch($sformatf("unexpected token kind %0d", token_kind));
            else
            begin
                want = expected_tokens.pop_front();
                if (token_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d (%s)",
                                              token_kind, want.kind, want.kind.name()));
                if (token_byte !== want.tbyte)
                    report_mismatch($sformatf("byte %02h, expected %02h",
                                              token_byte, want.tbyte));
                if (nest_depth !== want.depth)
                    report_mismatch($sformatf("depth %0d, expected %0d",
                                              nest_depth, want.depth));
                if (line_number !== want.line)
                    report_mismatch($sformatf("line %0d, expected %0d",
                                              line_number, want.line));
                if (column_number !== want.col)
                    report_mismatch($sformatf("column %0d, expected %0d",
                                              column_number, want.col));
            end
            out_count++;
        end
        if (rst_n && in_valid && in_ready)
        begin
            want = tokenize(data_byte, is_end);
            expected_tokens = {expected_tokens, want};
            in_accepts++;
        end
    end

    // Watchdog: too many cycles without any transaction ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
src/mtt_pkg.sv
src/mtt_classify.sv
src/mtt_queue.sv
src/mtt_engine.sv
src/markup_tag_tokenizer.sv
verif/tb.sv
